// File: src/frq_pkg.sv
// Shared constants, codes and types for the ready queue with remove.
// No dependencies; frq_if, frq_ctrl, the top level and frq_checker use it by scoped names.
package frq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ID_WIDTH    = 6;

  // Field widths of the words on the channels.
  localparam int ACT_W = 2;
  localparam int TID_W = 6;
  localparam int STS_W = 2;
  localparam int OID_W = 6;
  localparam int OCC_W = 7;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RMV = 2'd2;

  localparam logic [STS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESP
  } state_t;

  // Request from the sequencer to the entry RAM.
  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [ID_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]    raddr;
  } mem_req_t;

endpackage

// File: src/frq_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on frq_pkg for the field widths.
interface frq_in_if;
  logic                        valid;
  logic                        ready;
  logic [frq_pkg::ACT_W-1:0]   action;
  logic [frq_pkg::TID_W-1:0]   thread_id;

  modport source (output valid, output action, output thread_id, input ready);
  modport sink   (input valid, input action, input thread_id, output ready);
endinterface

interface frq_out_if;
  logic                        valid;
  logic                        ready;
  logic [frq_pkg::STS_W-1:0]   status;
  logic [frq_pkg::OID_W-1:0]   out_id;
  logic [frq_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, output status, output out_id, output occupancy, input ready);
  modport sink   (input valid, input status, input out_id, input occupancy, output ready);
endinterface

// File: src/frq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/frq_ctrl.sv
// Sequencer of the ready queue: takes a word, walks the entry RAM through
// its single read port, closes gaps, and holds the result word.
// Depends on frq_pkg and frq_if.
module frq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  frq_in_if.sink                        in_ch,
  frq_out_if.source                     out_ch,
  output frq_pkg::mem_req_t             mem_req,
  input  logic [frq_pkg::ID_WIDTH-1:0]  mem_rdata
);

  localparam int IDX_W = frq_pkg::IDX_W;
  localparam int CNT_W = frq_pkg::CNT_W;
  localparam int IDW   = frq_pkg::ID_WIDTH;
  localparam int STS_W = frq_pkg::STS_W;

  frq_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             pv_r, pv_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic             found_r, found_nxt;
  logic [IDW-1:0]   got_r, got_nxt;
  logic [IDW-1:0]   key_r, key_nxt;
  logic             deq_r, deq_nxt;
  logic [STS_W-1:0] sts_r, sts_nxt;

  logic                      ov_r, ov_nxt;
  logic [STS_W-1:0]          o_sts_r, o_sts_nxt;
  logic [frq_pkg::OID_W-1:0] o_id_r, o_id_nxt;
  logic [frq_pkg::OCC_W-1:0] o_occ_r, o_occ_nxt;

  logic in_acc, rd_en, walk_done, hit, out_free;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign rd_en     = rd_idx_r < cnt_r;
  assign walk_done = !rd_en && !pv_r;
  assign hit       = deq_r ? (pidx_r == '0) : (mem_rdata == key_r);
  assign out_free  = !ov_r || out_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frq_pkg::S_IDLE: begin
        if (in_acc) begin
          if ((in_ch.action == frq_pkg::ACT_DEQ || in_ch.action == frq_pkg::ACT_RMV) &&
              cnt_r != '0) begin
            state_nxt = frq_pkg::S_WALK;
          end else begin
            state_nxt = frq_pkg::S_RESP;
          end
        end
      end
      frq_pkg::S_WALK: begin
        if (walk_done) begin
          state_nxt = frq_pkg::S_RESP;
        end
      end
      frq_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = frq_pkg::S_IDLE;
        end
      end
      default: state_nxt = frq_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    in_ch.ready   = (state_r == frq_pkg::S_IDLE);
    mem_req.we    = 1'b0;
    mem_req.waddr = cnt_r[IDX_W-1:0];
    mem_req.wdata = key_r;
    mem_req.raddr = rd_idx_r[IDX_W-1:0];

    cnt_nxt    = cnt_r;
    rd_idx_nxt = rd_idx_r;
    pv_nxt     = pv_r;
    pidx_nxt   = pidx_r;
    found_nxt  = found_r;
    got_nxt    = got_r;
    key_nxt    = key_r;
    deq_nxt    = deq_r;
    sts_nxt    = sts_r;

    ov_nxt    = ov_r && !out_ch.ready;
    o_sts_nxt = o_sts_r;
    o_id_nxt  = o_id_r;
    o_occ_nxt = o_occ_r;

    case (state_r)
      frq_pkg::S_IDLE: begin
        if (in_acc) begin
          key_nxt    = in_ch.thread_id[IDW-1:0];
          deq_nxt    = (in_ch.action == frq_pkg::ACT_DEQ);
          rd_idx_nxt = '0;
          pv_nxt     = 1'b0;
          found_nxt  = 1'b0;
          got_nxt    = '0;
          sts_nxt    = frq_pkg::ST_OK;
          case (in_ch.action)
            frq_pkg::ACT_ENQ: begin
              if (cnt_r == CNT_W'(frq_pkg::QUEUE_DEPTH)) begin
                sts_nxt = frq_pkg::ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.wdata = in_ch.thread_id[IDW-1:0];
                cnt_nxt       = cnt_r + CNT_W'(1);
              end
            end
            frq_pkg::ACT_DEQ: begin
              if (cnt_r == '0) sts_nxt = frq_pkg::ST_EMPTY;
            end
            frq_pkg::ACT_RMV: begin
              if (cnt_r == '0) sts_nxt = frq_pkg::ST_NOTFOUND;
            end
            default: sts_nxt = frq_pkg::ST_OK;
          endcase
        end
      end
      frq_pkg::S_WALK: begin
        // Read entry rd_idx while the word of entry pidx arrives; once the
        // match is taken every later entry moves one place toward the head.
        rd_idx_nxt = rd_idx_r + CNT_W'(rd_en);
        pv_nxt     = rd_en;
        pidx_nxt   = rd_idx_r[IDX_W-1:0];
        if (pv_r) begin
          if (!found_r && hit) begin
            found_nxt = 1'b1;
            got_nxt   = mem_rdata;
          end else if (found_r) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pidx_r - IDX_W'(1);
            mem_req.wdata = mem_rdata;
          end
        end
        if (walk_done) begin
          sts_nxt = found_r ? frq_pkg::ST_OK : frq_pkg::ST_NOTFOUND;
          cnt_nxt = cnt_r - CNT_W'(found_r);
        end
      end
      frq_pkg::S_RESP: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          o_sts_nxt = sts_r;
          o_id_nxt  = frq_pkg::OID_W'(got_r);
          o_occ_nxt = frq_pkg::OCC_W'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.status    = o_sts_r;
  assign out_ch.out_id    = o_id_r;
  assign out_ch.occupancy = o_occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frq_pkg::S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      pv_r    <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    pidx_r   <= pidx_nxt;
    found_r  <= found_nxt;
    got_r    <= got_nxt;
    key_r    <= key_nxt;
    deq_r    <= deq_nxt;
    sts_r    <= sts_nxt;
    o_sts_r  <= o_sts_nxt;
    o_id_r   <= o_id_nxt;
    o_occ_r  <= o_occ_nxt;
  end

endmodule

// File: src/fifo_ready_queue_with_remove.sv
// First-come first-served queue of thread ids with enqueue, dequeue and remove by id.
// Enqueue, and any word that finds the queue full or empty or carries the unused action
// code, goes from acceptance straight to the result state, which loads the output register
// once it is free. Dequeue and remove walk every stored entry through the one read port of
// the entry RAM, finding the match and shifting the later entries toward the head in the
// same pass, then load the result. One word is in work at a time; a finished result waits
// in the output register while the next word is taken. No clearing pass.
// Depends on frq_pkg, frq_if, frq_ram and frq_ctrl.
module fifo_ready_queue_with_remove (
  input  logic       clk,
  input  logic       rst_n,
  frq_in_if.sink     in_ch,
  frq_out_if.source  out_ch
);

  frq_pkg::mem_req_t              mem_req;
  logic [frq_pkg::ID_WIDTH-1:0]   mem_rdata;

  frq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  frq_ram #(
    .DEPTH (frq_pkg::QUEUE_DEPTH),
    .WIDTH (frq_pkg::ID_WIDTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: src/frq_checker.sv
// Port-level checks of the ready queue, bound to the top level.
// Depends on frq_pkg and fifo_ready_queue_with_remove.
module frq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [frq_pkg::STS_W-1:0]   out_status,
  input logic [frq_pkg::OID_W-1:0]   out_id,
  input logic [frq_pkg::OCC_W-1:0]   out_occupancy
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != frq_pkg::ST_OK |-> out_id == '0)
    else $error("nonzero id on a failed action");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= frq_pkg::OCC_W'(frq_pkg::QUEUE_DEPTH))
    else $error("occupancy beyond depth");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_status != frq_pkg::ST_FULL ||
       out_occupancy == frq_pkg::OCC_W'(frq_pkg::QUEUE_DEPTH)) &&
      (out_status != frq_pkg::ST_EMPTY || out_occupancy == '0))
    else $error("full or empty status disagrees with occupancy");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_status) && $stable(out_id) && $stable(out_occupancy))
    else $error("stalled result word changed");

endmodule

bind fifo_ready_queue_with_remove frq_checker u_frq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_id        (out_ch.out_id),
  .out_occupancy (out_ch.occupancy)
);

// File: verif/fifo_ready_queue_with_remove_test.sv
// Self-checking test of fifo_ready_queue_with_remove: enqueue, dequeue and remove words go
// through the valid/ready channels, and a mirrored id queue predicts every result word.
// Depends on frq_pkg, frq_if and the RTL under src.

class ready_queue_scoreboard;
  typedef struct packed {
    logic [frq_pkg::STS_W-1:0] status;
    logic [frq_pkg::OID_W-1:0] out_id;
    logic [frq_pkg::OCC_W-1:0] occupancy;
  } result_word_t;

  logic [frq_pkg::ID_WIDTH-1:0] queued_ids[$];
  result_word_t                 pending_results[$];
  int                           errors;
  int                           results_seen;

  function new();
    errors       = 0;
    results_seen = 0;
  endfunction

  // Apply one accepted word to the mirror and queue the result it must give.
  function void note_word(input logic [frq_pkg::ACT_W-1:0] act,
                          input logic [frq_pkg::TID_W-1:0] tid);
    result_word_t                 want;
    logic [frq_pkg::ID_WIDTH-1:0] key;
    bit                           found;
    key   = tid[frq_pkg::ID_WIDTH-1:0];
    want  = '0;
    found = 1'b0;
    case (act)
      frq_pkg::ACT_ENQ: begin
        if (queued_ids.size() >= frq_pkg::QUEUE_DEPTH) want.status = frq_pkg::ST_FULL;
        else queued_ids.push_back(key);
      end
      frq_pkg::ACT_DEQ: begin
        if (queued_ids.size() == 0) want.status = frq_pkg::ST_EMPTY;
        else want.out_id = queued_ids.pop_front();
      end
      frq_pkg::ACT_RMV: begin
        want.status = frq_pkg::ST_NOTFOUND;
        for (int k = 0; k < queued_ids.size() && !found; k++) begin
          if (queued_ids[k] == key) begin
            want.out_id = key;
            want.status = frq_pkg::ST_OK;
            queued_ids.delete(k);
            found = 1'b1;
          end
        end
      end
      default: ;  // unused code: no change, ok status
    endcase
    want.occupancy = frq_pkg::OCC_W'(queued_ids.size());
    pending_results.push_back(want);
  endfunction

  function void check_word(input logic [frq_pkg::STS_W-1:0] status,
                           input logic [frq_pkg::OID_W-1:0] out_id,
                           input logic [frq_pkg::OCC_W-1:0] occupancy);
    result_word_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("unexpected result word: status %0d out_id %0d occupancy %0d",
             status, out_id, occupancy);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (status !== want.status) begin
      $error("status mismatch: expected %0d, actual %0d", want.status, status);
      errors++;
    end
    if (out_id !== want.out_id) begin
      $error("out_id mismatch: expected %0d, actual %0d", want.out_id, out_id);
      errors++;
    end
    if (occupancy !== want.occupancy) begin
      $error("occupancy mismatch: expected %0d, actual %0d", want.occupancy, occupancy);
      errors++;
    end
  endfunction
endclass

module fifo_ready_queue_with_remove_test;

  localparam logic [frq_pkg::ACT_W-1:0] ACT_NOP = 2'd3;
  localparam int RANDOM_WORDS = 1500;
  localparam int QUIET_AFTER  = 1300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 80;   // longer than a full-queue walk
  localparam int PRESSURE_LEN = 400;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } load_mode_e;

  logic clk;
  logic rst_n;
  bit   quiet;
  bit   pressure_done;

  ready_queue_scoreboard sb;

  frq_in_if  in_ch();
  frq_out_if out_ch();

  fifo_ready_queue_with_remove dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    quiet            = 1'b0;
    pressure_done    = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = '0;
    in_ch.thread_id  = '0;
    out_ch.ready     = 1'b0;
    sb               = new();
  end

  initial begin
    #2_000_000;
    $display("fifo_ready_queue_with_remove_test: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word(out_ch.status, out_ch.out_id, out_ch.occupancy);
  end

  // Result side: random stall bursts, calm stretches, one long hold-off.
  initial begin : result_side
    int calm_left;
    calm_left = 0;
    forever begin
      @(negedge clk);
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(50, 200);
      if (!pressure_done && sb.results_seen >= 150) begin
        // input must back up behind the held result word
        out_ch.ready <= 1'b0;
        repeat (PRESSURE_LEN - 1) @(negedge clk);
        pressure_done = 1'b1;
      end else if (quiet || calm_left > 0) begin
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic idle_in(input int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid     <= 1'b0;
      in_ch.action    <= frq_pkg::ACT_W'($urandom);
      in_ch.thread_id <= frq_pkg::TID_W'($urandom);
    end
  endtask

  task automatic send_word(input logic [frq_pkg::ACT_W-1:0] act,
                           input logic [frq_pkg::TID_W-1:0] tid);
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.thread_id <= tid;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(act, tid);
  endtask

  // Next random word for the given load mode; removes mostly target queued ids.
  function automatic void pick_word(input load_mode_e mode,
                                    output logic [frq_pkg::ACT_W-1:0] act,
                                    output logic [frq_pkg::TID_W-1:0] tid);
    int roll;
    int enq_pct;
    int deq_pct;
    int n;
    n    = sb.queued_ids.size();
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin enq_pct = 88; deq_pct = 4;  end
      MODE_DRAIN: begin enq_pct = 10; deq_pct = 40; end
      default:    begin enq_pct = 40; deq_pct = 27; end
    endcase
    if (roll < enq_pct) act = frq_pkg::ACT_ENQ;
    else if (roll < enq_pct + deq_pct) act = frq_pkg::ACT_DEQ;
    else if (roll < 95) act = frq_pkg::ACT_RMV;
    else act = ACT_NOP;
    if (act == frq_pkg::ACT_RMV && n > 0 && $urandom_range(0, 9) < 7)
      tid = sb.queued_ids[$urandom_range(0, n - 1)];
    else if ($urandom_range(0, 1) == 0)
      tid = frq_pkg::TID_W'($urandom_range(0, 7));   // small ids make duplicates common
    else
      tid = frq_pkg::TID_W'($urandom_range(0, 63));
  endfunction

  initial begin : stimulus
    logic [frq_pkg::ACT_W-1:0] act;
    logic [frq_pkg::TID_W-1:0] tid;
    load_mode_e                seg_mode;
    int                        seg_len;
    int                        sent;
    int                        waited;
    bit                        first_seg;
    bit                        gaps_on;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, extreme ids, duplicates, head/middle/tail removal
    send_word(frq_pkg::ACT_DEQ, 6'd0);
    send_word(frq_pkg::ACT_RMV, 6'd63);
    send_word(ACT_NOP, 6'd0);
    send_word(frq_pkg::ACT_ENQ, 6'd0);
    send_word(frq_pkg::ACT_ENQ, 6'd63);
    send_word(frq_pkg::ACT_ENQ, 6'd21);
    send_word(frq_pkg::ACT_ENQ, 6'd42);
    send_word(frq_pkg::ACT_ENQ, 6'd63);
    send_word(ACT_NOP, 6'd63);
    send_word(frq_pkg::ACT_RMV, 6'd63);
    send_word(frq_pkg::ACT_RMV, 6'd5);
    send_word(frq_pkg::ACT_RMV, 6'd0);
    send_word(frq_pkg::ACT_RMV, 6'd63);
    send_word(frq_pkg::ACT_RMV, 6'd63);
    send_word(frq_pkg::ACT_ENQ, 6'd42);
    send_word(frq_pkg::ACT_DEQ, 6'd0);
    send_word(frq_pkg::ACT_RMV, 6'd42);
    send_word(frq_pkg::ACT_DEQ, 6'd63);
    send_word(frq_pkg::ACT_DEQ, 6'd0);
    send_word(frq_pkg::ACT_RMV, 6'd42);

    sent      = 0;
    first_seg = 1'b1;
    while (sent < RANDOM_WORDS) begin
      // first segment is enqueue-heavy, to fill the queue to capacity
      seg_mode  = first_seg ? MODE_FILL : load_mode_e'($urandom_range(0, 2));
      seg_len   = (seg_mode == MODE_FILL) ? $urandom_range(90, 120) : $urandom_range(20, 90);
      gaps_on   = $urandom_range(0, 2) != 0;
      first_seg = 1'b0;
      for (int i = 0; i < seg_len && sent < RANDOM_WORDS; i++) begin
        pick_word(seg_mode, act, tid);
        if (gaps_on && !quiet && $urandom_range(0, 3) == 0)
          idle_in($urandom_range(1, 19));
        send_word(act, tid);
        sent++;
        if (sent == QUIET_AFTER) quiet = 1'b1;
      end
    end
    idle_in(1);

    waited = 0;
    while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending_results.size() != 0) begin
      $error("%0d result words never arrived", sb.pending_results.size());
      sb.errors++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0)
      $display("fifo_ready_queue_with_remove_test: clean");
    else
      $display("fifo_ready_queue_with_remove_test: errors");
    $finish;
  end
endmodule

// File: fifo_ready_queue_with_remove.f
src/frq_pkg.sv
src/frq_if.sv
src/frq_ram.sv
src/frq_ctrl.sv
src/fifo_ready_queue_with_remove.sv
src/frq_checker.sv
verif/fifo_ready_queue_with_remove_test.sv
